>>> src/rlr_pkg.sv
// Package for the retargetable linear ramp: widths, controller states,
// datapath operation codes and the command/status structs.
// No dependencies.
package rlr_pkg;

    // Level, fraction and length widths
    localparam int LEVEL_BITS      = 24;
    localparam int SLOPE_FRAC_BITS = 16;
    localparam int LENGTH_BITS     = 16;

    // Accumulator and divider sizing
    localparam int ACC_BITS  = LEVEL_BITS + SLOPE_FRAC_BITS;
    localparam int DIFF_BITS = ACC_BITS + 1;
    localparam int DIV_STEPS = (DIFF_BITS + 1) / 2;
    localparam int DIVD_BITS = 2 * DIV_STEPS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam int REM_BITS  = LENGTH_BITS + 1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS        = LEVEL_BITS + LENGTH_BITS;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((LEVEL_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_APPLY,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_PRIME,
        OP_HOLD,
        OP_STEP,
        OP_JUMP,
        OP_RETARGET,
        OP_DIV,
        OP_APPLY,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic primed;
        logic tgt_eq;
        logic slope_zero;
        logic len_zero;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

>>> src/retargetable_linear_ramp.sv
// Retargetable linear ramp envelope generator, top level.
// Joins controller rlr_ctrl and datapath rlr_dp; depends on rlr_pkg.
//
// Usage:
//   The slave stream takes one request per audio sample: tdata holds the
//   target level (signed, bits 23:0) and the ramp length in samples
//   (unsigned, bits 39:24). The master stream gives one level per request
//   (signed, bits 23:0), in request order.
//   A request is taken only while the controller is idle. A request that
//   holds or steps the ramp passes through decide and emit before its
//   result is valid. A request with a new target and a nonzero length runs
//   the slope division at two quotient bits per cycle, then apply and emit;
//   that divider loop sets the worst-case request rate.
//   The result sits in an output register, so the next request is taken
//   while the last result still waits; if the receiver stalls, the block
//   stops before writing the following result and holds until it is taken.
//   Reset (synchronous, active low) clears the ramp state; the first
//   request after reset loads its target level directly.
module retargetable_linear_ramp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: target_level[23:0], ramp_samples[39:24]
    input  logic [rlr_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: level_out[23:0]
    output logic [rlr_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata
);

    rlr_pkg::t_cmd    cmd;
    rlr_pkg::t_status status;

    rlr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    rlr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> src/rlr_ctrl.sv
// Controller of the retargetable linear ramp: sequences one request through
// decide, divide and apply (on a retarget only) and emit. Depends on rlr_pkg.
module rlr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  rlr_pkg::t_status i_status,
    output rlr_pkg::t_cmd    o_cmd
);

    rlr_pkg::t_state r_state;
    rlr_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.op        = rlr_pkg::OP_NONE;
        o_s_axis_tready = 1'b0;
        case (r_state)
            rlr_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.op = rlr_pkg::OP_LATCH;
                    n_state  = rlr_pkg::ST_DECIDE;
                end
            end
            rlr_pkg::ST_DECIDE: begin
                if (!i_status.primed) begin
                    o_cmd.op = rlr_pkg::OP_PRIME;
                    n_state  = rlr_pkg::ST_EMIT;
                end else if (i_status.tgt_eq && i_status.slope_zero) begin
                    o_cmd.op = rlr_pkg::OP_HOLD;
                    n_state  = rlr_pkg::ST_EMIT;
                end else if (i_status.tgt_eq) begin
                    o_cmd.op = rlr_pkg::OP_STEP;
                    n_state  = rlr_pkg::ST_EMIT;
                end else if (i_status.len_zero) begin
                    o_cmd.op = rlr_pkg::OP_JUMP;
                    n_state  = rlr_pkg::ST_EMIT;
                end else begin
                    o_cmd.op = rlr_pkg::OP_RETARGET;
                    n_state  = rlr_pkg::ST_DIV;
                end
            end
            rlr_pkg::ST_DIV: begin
                o_cmd.op = rlr_pkg::OP_DIV;
                if (i_status.div_last) begin
                    n_state = rlr_pkg::ST_APPLY;
                end
            end
            rlr_pkg::ST_APPLY: begin
                o_cmd.op = rlr_pkg::OP_APPLY;
                n_state  = rlr_pkg::ST_EMIT;
            end
            rlr_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = rlr_pkg::OP_EMIT;
                    n_state  = rlr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rlr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/rlr_dp.sv
// Datapath of the retargetable linear ramp: level accumulator, slope, ramp
// counters, two-bit-per-cycle restoring divider and output register.
// Depends on rlr_pkg.
module rlr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rlr_pkg::t_cmd                       i_cmd,
    output rlr_pkg::t_status                    o_status,
    input  logic [rlr_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [rlr_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata
);

    localparam int LB = rlr_pkg::LEVEL_BITS;
    localparam int FB = rlr_pkg::SLOPE_FRAC_BITS;
    localparam int NB = rlr_pkg::LENGTH_BITS;
    localparam int AB = rlr_pkg::ACC_BITS;
    localparam int DB = rlr_pkg::DIFF_BITS;
    localparam int QB = rlr_pkg::DIVD_BITS;
    localparam int CB = rlr_pkg::CNT_BITS;
    localparam int RB = rlr_pkg::REM_BITS;

    // Latched request
    logic [LB-1:0]        r_in_tgt;
    logic [NB-1:0]        r_in_len;
    // Ramp state
    logic signed [AB-1:0] r_acc,      n_acc;
    logic [LB-1:0]        r_held,     n_held;
    logic signed [AB-1:0] r_slope,    n_slope;
    logic [NB-1:0]        r_elapsed,  n_elapsed;
    logic [NB-1:0]        r_ramp_len, n_ramp_len;
    logic                 r_primed,   n_primed;
    // Divider
    logic [RB-1:0]        r_rem,      n_rem;
    logic [QB-1:0]        r_quo,      n_quo;
    logic                 r_neg,      n_neg;
    logic [CB-1:0]        r_cnt,      n_cnt;
    // Output register
    logic [LB-1:0]        r_out_level;
    logic                 r_out_valid, n_out_valid;

    logic signed [AB-1:0] tgt_acc;
    logic signed [AB-1:0] held_acc;
    logic signed [DB-1:0] diff;
    logic [DB-1:0]        mag;
    logic signed [AB-1:0] q_signed;
    logic [NB-1:0]        el_next;
    logic                 out_free;

    assign tgt_acc  = {r_in_tgt, {FB{1'b0}}};
    assign held_acc = {r_held, {FB{1'b0}}};
    assign diff     = {tgt_acc[AB-1], tgt_acc} - {r_acc[AB-1], r_acc};
    assign mag      = diff[DB-1] ? DB'(-diff) : DB'(diff);
    assign q_signed = r_neg ? AB'(-r_quo[AB-1:0]) : AB'(r_quo[AB-1:0]);
    assign el_next  = r_elapsed + NB'(1);
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Status to the controller
    assign o_status.primed     = r_primed;
    assign o_status.tgt_eq     = (r_in_tgt == r_held);
    assign o_status.slope_zero = (r_slope == '0);
    assign o_status.len_zero   = (r_in_len == '0);
    assign o_status.div_last   = (r_cnt == CB'(rlr_pkg::DIV_STEPS - 1));
    assign o_status.out_free   = out_free;

    // Next values of ramp state and divider
    always_comb begin
        logic signed [AB-1:0] slope_use;
        logic [RB-1:0]        rem_v;
        logic [QB-1:0]        quo_v;
        logic                 ge_v;
        n_acc       = r_acc;
        n_held      = r_held;
        n_slope     = r_slope;
        n_elapsed   = r_elapsed;
        n_ramp_len  = r_ramp_len;
        n_primed    = r_primed;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        slope_use   = r_slope;
        rem_v       = r_rem;
        quo_v       = r_quo;
        ge_v        = 1'b0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (i_cmd.op)
            rlr_pkg::OP_PRIME: begin
                n_primed   = 1'b1;
                n_held     = r_in_tgt;
                n_acc      = tgt_acc;
                n_slope    = '0;
                n_elapsed  = '0;
                n_ramp_len = '0;
            end
            rlr_pkg::OP_HOLD: begin
                n_acc = held_acc;
            end
            rlr_pkg::OP_JUMP: begin
                n_held     = r_in_tgt;
                n_ramp_len = r_in_len;
                n_elapsed  = '0;
                n_acc      = tgt_acc;
                n_slope    = '0;
            end
            rlr_pkg::OP_RETARGET: begin
                n_held     = r_in_tgt;
                n_ramp_len = r_in_len;
                n_elapsed  = '0;
                n_neg      = diff[DB-1];
                n_quo      = QB'(mag);
                n_rem      = '0;
                n_cnt      = '0;
            end
            rlr_pkg::OP_DIV: begin
                // Two restoring steps per cycle
                for (int k = 0; k < 2; k++) begin
                    rem_v = {rem_v[RB-2:0], quo_v[QB-1]};
                    ge_v  = (rem_v >= {1'b0, r_ramp_len});
                    if (ge_v) begin
                        rem_v = rem_v - {1'b0, r_ramp_len};
                    end
                    quo_v = {quo_v[QB-2:0], ge_v};
                end
                n_rem = rem_v;
                n_quo = quo_v;
                n_cnt = r_cnt + CB'(1);
            end
            rlr_pkg::OP_STEP, rlr_pkg::OP_APPLY: begin
                // Advance the ramp, or land on the target at its end
                if (i_cmd.op == rlr_pkg::OP_APPLY) begin
                    slope_use = q_signed;
                end
                n_elapsed = el_next;
                if (el_next != '0 && el_next < r_ramp_len) begin
                    n_acc   = r_acc + slope_use;
                    n_slope = slope_use;
                end else begin
                    n_acc   = held_acc;
                    n_slope = '0;
                end
            end
            rlr_pkg::OP_EMIT: begin
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_held      <= '0;
            r_slope     <= '0;
            r_elapsed   <= '0;
            r_ramp_len  <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_acc       <= n_acc;
            r_held      <= n_held;
            r_slope     <= n_slope;
            r_elapsed   <= n_elapsed;
            r_ramp_len  <= n_ramp_len;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_neg <= n_neg;
        if (i_cmd.op == rlr_pkg::OP_LATCH) begin
            r_in_tgt <= i_s_axis_tdata[LB-1:0];
            r_in_len <= i_s_axis_tdata[LB+NB-1:LB];
        end
        if (i_cmd.op == rlr_pkg::OP_EMIT) begin
            r_out_level <= r_acc[AB-1:FB];
        end
    end

    // Drive the result channel
    assign o_m_axis_tvalid = r_out_valid;
    always_comb begin
        o_m_axis_tdata         = '0;
        o_m_axis_tdata[LB-1:0] = r_out_level;
    end

    // Emit only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == rlr_pkg::OP_EMIT |-> out_free)
        else $error("result emitted over a pending one");

    // Emit raises the result valid
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == rlr_pkg::OP_EMIT |=> r_out_valid)
        else $error("emitted result not presented");

    // Divider runs only for a nonzero length
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == rlr_pkg::OP_DIV |-> r_ramp_len != '0)
        else $error("division by zero length");

    // A live slope means the ramp has not reached its end
    a_slope_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slope != '0 |-> (r_elapsed < r_ramp_len && r_primed))
        else $error("slope kept past end of ramp");

endmodule

>>> verif/retargetable_linear_ramp_tb.sv
// Self-checking testbench for retargetable_linear_ramp: a scoreboard class predicts
// every envelope level from accepted requests; tasks send requests, a loop throttles tready.
// Depends on rlr_pkg and the retargetable_linear_ramp RTL.
module retargetable_linear_ramp_tb;

    typedef logic signed [rlr_pkg::LEVEL_BITS-1:0] level_t;
    typedef logic [rlr_pkg::LENGTH_BITS-1:0]       length_t;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLDOFF_LEN = 300;

    // Predicts the ramp and keeps the levels still owed by the block
    class ramp_scoreboard;
        longint  level_acc;
        longint  slope;
        level_t  held_target;
        int      elapsed;
        int      ramp_len;
        bit      primed;
        level_t  owed_levels[$];
        int      mismatches;
        int      checked;

        function void note_request(level_t tgt, length_t len);
            longint tgt_acc;
            longint divisor;
            logic [63:0] shifted;
            bit jumped;
            tgt_acc = longint'(tgt) * 65536;
            divisor = len;
            jumped  = 0;
            if (!primed) begin
                // first request loads the level directly
                primed      = 1;
                held_target = tgt;
                level_acc   = tgt_acc;
                slope       = 0;
                elapsed     = 0;
                ramp_len    = 0;
            end else if (tgt == held_target && slope == 0) begin
                level_acc = longint'(held_target) * 65536;
            end else begin
                if (tgt != held_target) begin
                    held_target = tgt;
                    ramp_len    = len;
                    elapsed     = 0;
                    if (len == 0) begin
                        level_acc = tgt_acc;
                        slope     = 0;
                        jumped    = 1;
                    end else begin
                        slope = (tgt_acc - level_acc) / divisor;
                    end
                end
                // advance the ramp, snap to the target when it ends
                if (!jumped) begin
                    elapsed = (elapsed + 1) & 16'hFFFF;
                    if (elapsed != 0 && elapsed < ramp_len) begin
                        level_acc += slope;
                    end else begin
                        level_acc = longint'(held_target) * 65536;
                        slope     = 0;
                    end
                end
            end
            shifted = level_acc >>> rlr_pkg::SLOPE_FRAC_BITS;
            owed_levels.push_back(shifted[rlr_pkg::LEVEL_BITS-1:0]);
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR: %s", msg);
        endtask

        task check_level(logic [rlr_pkg::LEVEL_BITS-1:0] got);
            level_t want;
            if (owed_levels.size() == 0) begin
                report($sformatf("level %0d arrived with no request pending", $signed(got)));
            end else begin
                want = owed_levels.pop_front();
                if (got !== want)
                    report($sformatf("level %0d: got %0d, expected %0d",
                                     checked, $signed(got), want));
            end
            checked++;
        endtask

        task flush_leftovers();
            while (owed_levels.size() != 0) begin
                report($sformatf("expected level %0d never arrived",
                                 owed_levels.pop_front()));
            end
        endtask

        function int pending();
            return owed_levels.size();
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_s_axis_tvalid;
    logic                                o_s_axis_tready;
    logic [rlr_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready;
    logic [rlr_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata;

    ramp_scoreboard board = new();
    int     tx_idle_pct;
    int     rx_idle_pct;
    logic   rx_hold;
    int     sent;
    level_t last_tgt;
    int     cycles;

    retargetable_linear_ramp uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the total cycle count
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receive side: check each taken level, throttle tready at random
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1)
                board.check_level(o_m_axis_tdata[rlr_pkg::LEVEL_BITS-1:0]);
            i_m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one request, with a random gap first; return once it is accepted
    task automatic send_request(level_t tgt, length_t len);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {len, tgt};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        board.note_request(tgt, len);
        last_tgt = tgt;
        sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Stall the receiver for a long stretch in a process of its own
    task automatic start_holdoff();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLDOFF_LEN) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
    endtask

    // One retarget followed by a run of samples at that target, or one noise sample
    task automatic run_ramp_burst();
        level_t  tgt;
        length_t len;
        int      pick;
        int      hold;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: a fresh random target on every sample
            send_request(level_t'($urandom()), length_t'($urandom()));
        end else begin
            pick = $urandom_range(99);
            if (pick < 15)
                tgt = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            else if (pick < 30)
                tgt = level_t'(last_tgt + level_t'($urandom_range(6)) - 3);
            else
                tgt = level_t'($urandom());
            pick = $urandom_range(99);
            if (pick < 10)
                len = '0;
            else if (pick < 20)
                len = length_t'($urandom());
            else
                len = length_t'($urandom_range(40, 1));
            if (len <= 40 && $urandom_range(3) != 0)
                hold = $urandom_range(len + 4, 1);
            else
                hold = $urandom_range(20, 1);
            send_request(tgt, len);
            repeat (hold - 1) send_request(tgt, length_t'($urandom()));
        end
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int goal, bit holdoff, bit pause);
        int half;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        half = sent + goal / 2;
        while (sent < half) run_ramp_burst();
        if (holdoff) start_holdoff();
        if (pause) wait_drained();
        half = half + goal / 2;
        while (sent < half) run_ramp_burst();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        rx_hold         <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        sent        = 0;
        last_tgt    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: priming load, hold, jump, one-sample ramp, short ramp
        send_request(24'sh800000, 16'hFFFF);
        send_request(24'sh800000, 16'h0000);
        send_request(24'sh7FFFFF, 16'h0000);
        send_request(24'sh7FFFFF, 16'h1234);
        send_request(24'sh800000, 16'h0001);
        repeat (5) send_request(24'sh000000, 16'h0004);
        // slope truncated to zero: tiny fractional gap over the longest ramp
        send_request(24'sh000001, 16'h0003);
        send_request(24'sh000000, 16'hFFFF);
        repeat (2) send_request(24'sh000000, 16'h0000);
        // retarget in the middle of long ramps, then jump away
        repeat (3) send_request(24'sh7FFFFF, 16'hFFFF);
        repeat (3) send_request(24'sh800000, 16'hFFFF);
        send_request(24'sh000064, 16'h0000);
        wait_drained();

        // random: three throttling phases
        run_phase(18, 59, 600, 1'b1, 1'b0);
        wait_drained();
        run_phase(59, 18, 600, 1'b0, 1'b1);
        wait_drained();
        run_phase(0, 0, 620, 1'b1, 1'b1);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        board.flush_leftovers();

        $display("Covered %0d requests (priming, jumps, ramps, retargets) under three",
                 sent);
        $display("throttling phases with receiver hold-off; %0d levels compared.",
                 board.checked);
        if (board.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/rlr_pkg.sv
src/rlr_ctrl.sv
src/rlr_dp.sv
src/retargetable_linear_ramp.sv
verif/retargetable_linear_ramp_tb.sv
